### hdl/jdcm_pkg.sv
// ----------------------------------------------------------------------------
// Joystick dead zone package
// Widths, fixed-point constants, register indexes and the sequencer state type
// shared by the dead-zone and disc-mapping logic.
// ----------------------------------------------------------------------------
package jdcm_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W   = 16;
   localparam int KEPT_W     = 17;
   localparam int MAG_IN_W   = 16;
   localparam int RADIUS_W   = 15;
   localparam int STICK_W    = 2;
   localparam int POS_W      = 9;
   localparam int CSR_IDX_W  = 4;
   localparam int FRAC_BITS  = 18;
   localparam int NORM_W     = 19;
   localparam int HALF_W     = 19;
   localparam int ROOT_W     = 19;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = 21;
   localparam int STEP_W     = 5;

   // The product n * s * scale is reduced by 2^36; the serial multiplier has
   // already dropped ROOT_W of those bits.
   localparam int MULT_SHIFT = 2 * FRAC_BITS - ROOT_W;

   // Full-scale axis value and snap targets.
   localparam logic [MAG_IN_W-1:0] AXIS_FULL = 16'd32767;
   localparam logic [KEPT_W-1:0]   SNAP_POS  = 17'h08000;
   localparam logic [KEPT_W-1:0]   SNAP_NEG  = 17'h18000;
   localparam logic [HALF_W-1:0]   FIXED_ONE = 19'h40000;

   // Register reset values.
   localparam logic [RADIUS_W-1:0] MOVING_RADIUS_RST = 15'd5000;
   localparam logic [RADIUS_W-1:0] STATIC_RADIUS_RST = 15'd10000;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MOVING_RADIUS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STATIC_RADIUS = 4'd1;

   // Last step of each bit-serial loop.
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd18;

   // Sequencer states.
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_READ   = 9'b000000010,
      ST_FILTER = 9'b000000100,
      ST_NORM   = 9'b000001000,
      ST_SQUARE = 9'b000010000,
      ST_RADIC  = 9'b000100000,
      ST_ROOT   = 9'b001000000,
      ST_MULT   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

endpackage

### hdl/joystick_deadzone_circular_map.sv
// ----------------------------------------------------------------------------
// Joystick dead zone with circular mapping
// Filters one axis sample per word through static and moving dead zones,
// keeps the result per stick and axis, and maps both kept axes of the stick
// from the square onto the disc with bit-serial square, root and multiply.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  req     | in        | req_valid/req_ready | stick_index, axis_select, sample
//  rsp     | out       | rsp_valid/rsp_ready | stick_id, pos_horizontal, pos_vertical
//  csr     | in        | csr_wr_en           | csr_index, csr_wr_data
//
//  The block accepts a new word only in its idle state, so it finishes one
//  word before it takes the next. Each word runs through three bit-serial
//  loops of 19 steps each (square of the other axis, square root, final
//  scaling multiply).
//  Reset loads the radius registers and marks every kept value as zero at
//  once through per-entry valid bits; no clearing sweep is needed.
//  A finished result waits in the output register while the next word is
//  taken; a new result waits in the last step until the register is free.
// ----------------------------------------------------------------------------
module joystick_deadzone_circular_map
   import jdcm_pkg::*;
#(
   parameter int NUM_STICKS = 4,
   parameter int OUT_SCALE  = 255
) (
   input  logic                       clock,
   input  logic                       reset,
   // Input words
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [STICK_W-1:0]         req_stick_index,
   input  logic                       req_axis_select,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   // Result words
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STICK_W-1:0]         rsp_stick_id,
   output logic signed [POS_W-1:0]    rsp_pos_horizontal,
   output logic signed [POS_W-1:0]    rsp_pos_vertical,
   // Register writes
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [RADIUS_W-1:0]        csr_wr_data
);

   localparam int DEPTH = 2 * NUM_STICKS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OS_W  = $clog2(OUT_SCALE + 1);
   localparam int PA_W  = NORM_W + OS_W;
   localparam int MAG_W = PA_W - MULT_SHIFT;

   // Reduce a stick number into the configured stick count.
   function automatic logic [STICK_W-1:0] reduce_stick(input logic [STICK_W-1:0] raw);
      logic [STICK_W-1:0] v;
      v = raw;
      for (int i = 0; i < (1 << STICK_W) - 1; i++) begin
         if (int'(v) >= NUM_STICKS) begin
            v = v - STICK_W'(NUM_STICKS);
         end
      end
      return v;
   endfunction

   // Control registers.
   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RADIUS_W-1:0]   moving_radius_ff, moving_radius_in;
   logic [RADIUS_W-1:0]   static_radius_ff, static_radius_in;

   // Captured input word.
   logic [STICK_W-1:0]         stick_ff, stick_in;
   logic                       axis_ff, axis_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;

   // Per-axis lanes: index 0 horizontal, 1 vertical.
   logic signed [KEPT_W-1:0] kept_ff [2];
   logic signed [KEPT_W-1:0] kept_in [2];
   logic [NORM_W-1:0]        norm_ff [2];
   logic [NORM_W-1:0]        norm_in [2];
   logic [RAD_W-1:0]         shift_ff [2];
   logic [RAD_W-1:0]         shift_in [2];
   logic [HALF_W-1:0]        half_ff [2];
   logic [HALF_W-1:0]        half_in [2];
   logic [REM_W-1:0]         rem_ff [2];
   logic [REM_W-1:0]         rem_in [2];
   logic [ROOT_W-1:0]        root_ff [2];
   logic [ROOT_W-1:0]        root_in [2];
   logic [PA_W-1:0]          scale_ff [2];
   logic [PA_W-1:0]          scale_in [2];
   logic [PA_W-1:0]          prod_ff [2];
   logic [PA_W-1:0]          prod_in [2];

   // Output register.
   logic [STICK_W-1:0]      rsp_stick_ff, rsp_stick_in;
   logic signed [POS_W-1:0] rsp_pos_h_ff, rsp_pos_h_in;
   logic signed [POS_W-1:0] rsp_pos_v_ff, rsp_pos_v_in;

   // Kept-value memory with per-entry valid bits.
   logic signed [KEPT_W-1:0] kept_mem_ff [DEPTH];
   logic [DEPTH-1:0]         kept_ok_ff;
   logic signed [KEPT_W-1:0] rd_ff [2];
   logic                     rd_ok_ff [2];
   logic [IDX_W-1:0]         rd_idx [2];
   logic [IDX_W-1:0]         wr_idx;
   logic                     mem_wr_en;

   // Lane arithmetic.
   logic signed [KEPT_W-1:0] rd_val [2];
   logic signed [KEPT_W-1:0] kept_cur;
   logic signed [KEPT_W-1:0] samp_x;
   logic [KEPT_W-1:0]        samp_mag;
   logic signed [KEPT_W:0]   diff_s;
   logic [KEPT_W:0]          diff_mag;
   logic [MAG_IN_W-1:0]      full_lim;
   logic signed [KEPT_W-1:0] filt_pos;
   logic [MAG_IN_W-1:0]      axis_mag [2];
   logic [NORM_W-1:0]        norm_t [2];
   logic [3:0]               norm_k0 [2];
   logic [MAG_IN_W-1:0]      norm_rem [2];
   logic [3:0]               norm_k [2];
   logic [NORM_W-1:0]        norm_val [2];
   logic [HALF_W:0]          sq_sum [2];
   logic [HALF_W-1:0]        rad_r [2];
   logic [REM_W+1:0]         rem_sh [2];
   logic [REM_W+1:0]         trial [2];
   logic                     root_take [2];
   logic [PA_W:0]            prod_sum [2];
   logic [MAG_W-1:0]         mag_raw [2];
   logic [MAG_W-1:0]         mag_lim [2];
   logic [POS_W-1:0]         pos_out [2];

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stick_id       = rsp_stick_ff;
   assign rsp_pos_horizontal = rsp_pos_h_ff;
   assign rsp_pos_vertical   = rsp_pos_v_ff;

   // Dead-zone filter on the captured sample against the kept value.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rd_idx[l] = IDX_W'({stick_ff, 1'(l)});
         rd_val[l] = rd_ok_ff[l] ? rd_ff[l] : '0;
      end
      wr_idx   = IDX_W'({stick_ff, axis_ff});
      kept_cur = axis_ff ? rd_val[1] : rd_val[0];
      samp_x   = KEPT_W'(sample_ff);
      samp_mag = samp_x[KEPT_W-1] ? KEPT_W'(-samp_x) : KEPT_W'(samp_x);
      diff_s   = (KEPT_W + 1)'(samp_x) - (KEPT_W + 1)'(kept_cur);
      diff_mag = diff_s[KEPT_W] ? (KEPT_W + 1)'(-diff_s) : (KEPT_W + 1)'(diff_s);
      full_lim = AXIS_FULL - MAG_IN_W'(static_radius_ff);
      if (samp_mag > KEPT_W'(full_lim)) begin
         filt_pos = samp_x[KEPT_W-1] ? SNAP_NEG : SNAP_POS;
      end else if (samp_mag < KEPT_W'(static_radius_ff)) begin
         filt_pos = '0;
      end else if (diff_mag > (KEPT_W + 1)'(moving_radius_ff)) begin
         filt_pos = samp_x;
      end else begin
         filt_pos = kept_cur;
      end
   end

   // Per-lane normalization, serial square, root and multiply steps.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         // n = 8m + floor(8m / 32767), exact for m up to 32768.
         axis_mag[l] = kept_ff[l][KEPT_W-1] ? MAG_IN_W'(-kept_ff[l]) : MAG_IN_W'(kept_ff[l]);
         norm_t[l]   = {axis_mag[l], 3'b000};
         norm_k0[l]  = norm_t[l][NORM_W-1:15];
         norm_rem[l] = MAG_IN_W'(norm_t[l][14:0]) + MAG_IN_W'(norm_k0[l]);
         norm_k[l]   = norm_k0[l] + 4'(norm_rem[l] >= AXIS_FULL);
         norm_val[l] = norm_t[l] + NORM_W'(norm_k[l]);

         // Square of the other axis, LSB first, halved by the extra shift.
         sq_sum[l] = {1'b0, half_ff[l]}
                   + (shift_ff[l][0] ? {1'b0, norm_ff[1 - l]} : '0);

         // Radicand base: one minus half the square, floored at zero.
         rad_r[l] = (half_ff[l] >= FIXED_ONE) ? '0 : FIXED_ONE - half_ff[l];

         // Restoring square root, one result bit per step.
         rem_sh[l]    = {rem_ff[l], shift_ff[l][RAD_W-1 -: 2]};
         trial[l]     = {2'b00, root_ff[l], 2'b01};
         root_take[l] = (rem_sh[l] >= trial[l]);

         // Scaling multiply, root bits LSB first.
         prod_sum[l] = {1'b0, prod_ff[l]} + (root_ff[l][0] ? {1'b0, scale_ff[l]} : '0);

         // Final magnitude, clamp and sign.
         mag_raw[l] = prod_ff[l][PA_W-1:MULT_SHIFT];
         mag_lim[l] = (mag_raw[l] > MAG_W'(OUT_SCALE)) ? MAG_W'(OUT_SCALE) : mag_raw[l];
         pos_out[l] = kept_ff[l][KEPT_W-1] ? POS_W'(0) - POS_W'(mag_lim[l])
                                           : POS_W'(mag_lim[l]);
      end
   end

   // Sequencer and next-state values.
   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      rsp_valid_in     = rsp_ready ? 1'b0 : rsp_valid_ff;
      moving_radius_in = moving_radius_ff;
      static_radius_in = static_radius_ff;
      stick_in         = stick_ff;
      axis_in          = axis_ff;
      sample_in        = sample_ff;
      rsp_stick_in     = rsp_stick_ff;
      rsp_pos_h_in     = rsp_pos_h_ff;
      rsp_pos_v_in     = rsp_pos_v_ff;
      mem_wr_en        = 1'b0;
      for (int l = 0; l < 2; l++) begin
         kept_in[l]  = kept_ff[l];
         norm_in[l]  = norm_ff[l];
         shift_in[l] = shift_ff[l];
         half_in[l]  = half_ff[l];
         rem_in[l]   = rem_ff[l];
         root_in[l]  = root_ff[l];
         scale_in[l] = scale_ff[l];
         prod_in[l]  = prod_ff[l];
      end

      // Register writes.
      if (csr_wr_en) begin
         case (csr_index)
            REG_MOVING_RADIUS: moving_radius_in = csr_wr_data;
            REG_STATIC_RADIUS: static_radius_in = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               stick_in  = reduce_stick(req_stick_index);
               axis_in   = req_axis_select;
               sample_in = req_sample;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FILTER;
         end
         ST_FILTER: begin
            kept_in[0] = axis_ff ? rd_val[0] : filt_pos;
            kept_in[1] = axis_ff ? filt_pos : rd_val[1];
            mem_wr_en  = 1'b1;
            state_in   = ST_NORM;
         end
         ST_NORM: begin
            for (int l = 0; l < 2; l++) begin
               norm_in[l]  = norm_val[l];
               shift_in[l] = RAD_W'(norm_val[1 - l]);
               half_in[l]  = '0;
            end
            step_in  = '0;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            for (int l = 0; l < 2; l++) begin
               half_in[l]  = sq_sum[l][HALF_W:1];
               shift_in[l] = shift_ff[l] >> 1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_RADIC;
            end
         end
         ST_RADIC: begin
            for (int l = 0; l < 2; l++) begin
               shift_in[l] = {1'b0, rad_r[l], FRAC_BITS'(0)};
               rem_in[l]   = '0;
               root_in[l]  = '0;
               scale_in[l] = PA_W'(norm_ff[l]) * PA_W'(OUT_SCALE);
               prod_in[l]  = '0;
            end
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            for (int l = 0; l < 2; l++) begin
               rem_in[l]   = root_take[l] ? REM_W'(rem_sh[l] - trial[l]) : REM_W'(rem_sh[l]);
               root_in[l]  = {root_ff[l][ROOT_W-2:0], root_take[l]};
               shift_in[l] = shift_ff[l] << 2;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            for (int l = 0; l < 2; l++) begin
               prod_in[l] = prod_sum[l][PA_W:1];
               root_in[l] = root_ff[l] >> 1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_stick_in = stick_ff;
               rsp_pos_h_in = pos_out[0];
               rsp_pos_v_in = pos_out[1];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         moving_radius_ff <= MOVING_RADIUS_RST;
         static_radius_ff <= STATIC_RADIUS_RST;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         rsp_valid_ff     <= rsp_valid_in;
         moving_radius_ff <= moving_radius_in;
         static_radius_ff <= static_radius_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      stick_ff     <= stick_in;
      axis_ff      <= axis_in;
      sample_ff    <= sample_in;
      rsp_stick_ff <= rsp_stick_in;
      rsp_pos_h_ff <= rsp_pos_h_in;
      rsp_pos_v_ff <= rsp_pos_v_in;
      for (int l = 0; l < 2; l++) begin
         kept_ff[l]  <= kept_in[l];
         norm_ff[l]  <= norm_in[l];
         shift_ff[l] <= shift_in[l];
         half_ff[l]  <= half_in[l];
         rem_ff[l]   <= rem_in[l];
         root_ff[l]  <= root_in[l];
         scale_ff[l] <= scale_in[l];
         prod_ff[l]  <= prod_in[l];
      end
   end

   // Kept-value memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         kept_mem_ff[wr_idx] <= filt_pos;
      end
      for (int l = 0; l < 2; l++) begin
         rd_ff[l] <= kept_mem_ff[rd_idx[l]];
      end
   end

   // Valid bits: an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ok_ff <= '0;
         for (int l = 0; l < 2; l++) begin
            rd_ok_ff[l] <= 1'b0;
         end
      end else begin
         if (mem_wr_en) begin
            kept_ok_ff[wr_idx] <= 1'b1;
         end
         for (int l = 0; l < 2; l++) begin
            rd_ok_ff[l] <= kept_ok_ff[rd_idx[l]];
         end
      end
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick dead zone testbench
// Drives axis sample words through the dead-zone and disc-mapping block,
// predicts every stick position word with its own fixed-point model of the
// filter and the square-to-disc map, and compares each result field by field.
// Register settings are changed only while the block is drained.
// ----------------------------------------------------------------------------
module tb;
   import jdcm_pkg::*;

   localparam int NUM_STICKS  = 4;
   localparam int OUT_SCALE   = 255;
   localparam int FULL_SCALE  = 32767;
   localparam int SNAP_MAG    = 32768;
   localparam int IDLE_LIMIT  = 3000;
   localparam int HOLDOFF_LEN = 400;

   // One expected position word.
   typedef struct packed {
      logic [STICK_W-1:0]      stick_id;
      logic signed [POS_W-1:0] pos_horizontal;
      logic signed [POS_W-1:0] pos_vertical;
   } position_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [STICK_W-1:0]         req_stick_index = '0;
   logic                       req_axis_select = 1'b0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STICK_W-1:0]         rsp_stick_id;
   logic signed [POS_W-1:0]    rsp_pos_horizontal;
   logic signed [POS_W-1:0]    rsp_pos_vertical;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [RADIUS_W-1:0]        csr_wr_data = '0;

   // Predictor state: radius settings and the kept value of every axis.
   logic [RADIUS_W-1:0]      moving_r = MOVING_RADIUS_RST;
   logic [RADIUS_W-1:0]      static_r = STATIC_RADIUS_RST;
   logic signed [KEPT_W-1:0] kept_axis [NUM_STICKS*2];

   position_word_type pending_positions [$];
   int             error_count = 0;
   int             idle_cycles = 0;
   int             burst_left  = 0;
   bit             pacing      = 1'b1;
   bit             rx_stall_en = 1'b1;
   int             holdoff_left = 0;
   int             rx_run = 0;
   bit             rx_level = 1'b1;

   joystick_deadzone_circular_map #(
      .NUM_STICKS (NUM_STICKS),
      .OUT_SCALE  (OUT_SCALE)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_stick_index    (req_stick_index),
      .req_axis_select    (req_axis_select),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_stick_id       (rsp_stick_id),
      .rsp_pos_horizontal (rsp_pos_horizontal),
      .rsp_pos_vertical   (rsp_pos_vertical),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Integer square root, built one result bit at a time from the top.
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 19; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // Normalized magnitude of a kept axis value, 18 fractional bits.
   function automatic longint unsigned norm_axis(input int k);
      longint unsigned m;
      m = (k < 0) ? longint'(-k) : longint'(k);
      return (m << FRAC_BITS) / FULL_SCALE;
   endfunction

   // Square-to-disc position of one axis given the other axis.
   function automatic logic signed [POS_W-1:0] disc_position(input int own, input int other);
      longint unsigned n_own, n_other, sq, half, one, radicand, root, mag;
      n_own    = norm_axis(own);
      n_other  = norm_axis(other);
      sq       = (n_other * n_other) >> FRAC_BITS;
      one      = 64'd1 << FRAC_BITS;
      half     = sq >> 1;
      radicand = (half >= one) ? 64'd0 : one - half;
      root     = int_sqrt(radicand << FRAC_BITS);
      mag      = (n_own * root * OUT_SCALE) >> (2 * FRAC_BITS);
      if (mag > OUT_SCALE) mag = OUT_SCALE;
      if (own < 0) return POS_W'(-mag);
      return POS_W'(mag);
   endfunction

   // Filters one sample into the kept state and returns the position word.
   function automatic position_word_type filter_and_map(input logic [STICK_W-1:0] stick_in,
                                                        input logic axis,
                                                        input logic signed [SAMPLE_W-1:0] sample);
      position_word_type word;
      int stick, base, v, mag, kept, diff, next;
      stick = int'(stick_in) % NUM_STICKS;
      base  = stick * 2;
      v     = sample;
      mag   = (v < 0) ? -v : v;
      kept  = kept_axis[base + axis];
      diff  = (v > kept) ? v - kept : kept - v;
      // Snap-to-full is tested first, so it wins where the zones overlap.
      if (mag > FULL_SCALE - int'(static_r)) next = (v < 0) ? -SNAP_MAG : SNAP_MAG;
      else if (mag < int'(static_r)) next = 0;
      else if (diff > int'(moving_r)) next = v;
      else next = kept;
      kept_axis[base + axis] = next[KEPT_W-1:0];
      word.stick_id       = stick[STICK_W-1:0];
      word.pos_horizontal = disc_position(kept_axis[base], kept_axis[base + 1]);
      word.pos_vertical   = disc_position(kept_axis[base + 1], kept_axis[base]);
      return word;
   endfunction

   // Random sample, weighted toward the zone edges and the moving threshold.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int slot);
      int kind, v, jitter;
      kind   = $urandom_range(0, 9);
      jitter = int'($urandom_range(0, 6)) - 3;
      case (kind)
         0, 1, 2: v = int'($urandom_range(0, 65535)) - SNAP_MAG;
         3, 4: v = int'(static_r) + jitter;
         5: v = FULL_SCALE - int'(static_r) + jitter;
         default: v = int'(kept_axis[slot]) + int'(moving_r) + jitter;
      endcase
      if (kind >= 3 && kind <= 5 && $urandom_range(0, 1)) v = -v;
      if (kind > 5 && $urandom_range(0, 1))
         v = int'(kept_axis[slot]) - int'(moving_r) - jitter;
      if (v > FULL_SCALE) v = FULL_SCALE;
      if (v < -SNAP_MAG) v = -SNAP_MAG;
      return v[SAMPLE_W-1:0];
   endfunction

   // Sends one sample word; bursts are separated by random gaps when pacing.
   task automatic send_word(input logic [STICK_W-1:0] stick, input logic axis,
                            input logic signed [SAMPLE_W-1:0] sample);
      if (burst_left == 0) begin
         if (pacing) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_stick_index <= stick;
      req_axis_select <= axis;
      req_sample      <= sample;
      do @(posedge clock); while (!req_ready);
      pending_positions.push_back(filter_and_map(stick, axis, sample));
   endtask

   task automatic send_random_word();
      logic [STICK_W-1:0] stick;
      logic               axis;
      stick = STICK_W'($urandom_range(0, 3));
      axis  = 1'($urandom_range(0, 1));
      send_word(stick, axis, pick_sample((int'(stick) % NUM_STICKS) * 2 + axis));
   endtask

   // Stops sending and waits until every predicted word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [RADIUS_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      if (idx == REG_MOVING_RADIUS) moving_r = data;
      else if (idx == REG_STATIC_RADIUS) static_r = data;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_radii(input logic [RADIUS_W-1:0] moving, input logic [RADIUS_W-1:0] zone);
      drain();
      csr_write(REG_MOVING_RADIUS, moving);
      csr_write(REG_STATIC_RADIUS, zone);
   endtask

   // Zone edges and the moving threshold at the reset radii, on every stick.
   task automatic test_reset_defaults();
      send_word(0, 0, 16'sd0);
      send_word(0, 0, 16'sd32767);
      send_word(0, 1, -16'sd32768);
      send_word(0, 0, 16'sd22767);
      send_word(0, 0, 16'sd22768);
      send_word(0, 1, 16'sd9999);
      send_word(0, 1, 16'sd10000);
      send_word(0, 1, 16'sd15000);
      send_word(0, 1, 16'sd15001);
      send_word(0, 1, -16'sd10000);
      send_word(1, 0, -16'sd22767);
      send_word(1, 1, 16'sd22767);
      send_word(2, 0, -16'sd32767);
      send_word(2, 1, -16'sd32767);
      send_word(3, 0, 16'sd12345);
      send_word(3, 1, -16'sd20000);
      send_word(3, 0, -16'sd9999);
   endtask

   // Overlapping zones and the extreme radius values.
   task automatic test_zone_extremes();
      set_radii(15'd5000, 15'd20000);
      send_word(0, 0, 16'sd15000);
      send_word(1, 1, -16'sd12768);
      send_word(2, 0, 16'sd12767);
      set_radii(15'd0, 15'd32767);
      send_word(0, 0, 16'sd1);
      send_word(0, 0, 16'sd0);
      set_radii(15'd0, 15'd0);
      send_word(0, 0, 16'sd100);
      send_word(0, 0, 16'sd100);
      send_word(0, 0, 16'sd101);
      send_word(0, 1, -16'sd32767);
      send_word(1, 0, 16'sd32767);
      set_radii(15'd32767, 15'd0);
      send_word(0, 0, -16'sd30000);
      send_word(0, 1, 16'sd32767);
   endtask

   // Writes to unused register indexes must leave the radii alone.
   task automatic test_unused_registers();
      int idx;
      set_radii(15'd5000, 15'd10000);
      for (idx = int'(REG_STATIC_RADIUS) + 1; idx < (1 << CSR_IDX_W); idx++)
         csr_write(idx[CSR_IDX_W-1:0], RADIUS_W'($urandom_range(0, 32767)));
      repeat (16) send_random_word();
   endtask

   // A sweep of radius settings, extremes first, random traffic under each.
   task automatic test_radius_sweep();
      logic [RADIUS_W-1:0] sweep_moving [8];
      logic [RADIUS_W-1:0] sweep_zone [8];
      sweep_moving = '{15'd0, 15'd32767, 15'd0, 15'd32767, 15'd1, 15'd0, 15'd0, 15'd0};
      sweep_zone   = '{15'd0, 15'd32767, 15'd32767, 15'd0, 15'd16384, 15'd0, 15'd0, 15'd0};
      for (int i = 5; i < 8; i++) begin
         sweep_moving[i] = RADIUS_W'($urandom_range(0, 32767));
         sweep_zone[i]   = RADIUS_W'($urandom_range(0, 32767));
      end
      for (int i = 0; i < 8; i++) begin
         set_radii(sweep_moving[i], sweep_zone[i]);
         repeat (60) send_random_word();
      end
   endtask

   // Long random run under moderate radii, changing pacing and stalls per phase.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         set_radii(RADIUS_W'($urandom_range(0, 8000)), RADIUS_W'($urandom_range(0, 16000)));
         pacing      = (phase != 2);
         rx_stall_en = (phase != 2) && (phase != 4);
         repeat (120) send_random_word();
      end
      pacing      = 1'b1;
      rx_stall_en = 1'b1;
   endtask

   // The receiver holds off long enough for the block to stall its input.
   task automatic test_output_holdoff();
      drain();
      pacing       = 1'b0;
      holdoff_left = HOLDOFF_LEN;
      repeat (12) send_random_word();
      pacing = 1'b1;
      drain();
   endtask

   // Result ready: a long hold-off, always ready, or random stall runs.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (!rx_stall_en) begin
         rsp_ready <= 1'b1;
      end else begin
         if (rx_run == 0) begin
            rx_level = ($urandom_range(0, 2) != 0);
            rx_run   = $urandom_range(1, 12);
         end
         rx_run--;
         rsp_ready <= rx_level;
      end
   end

   // Compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      position_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_positions.size() == 0) begin
            error_count++;
            $error("result word with no prediction pending");
         end else begin
            want = pending_positions.pop_front();
            if (rsp_stick_id !== want.stick_id) begin
               error_count++;
               $error("stick_id expected %0d actual %0d", want.stick_id, rsp_stick_id);
            end
            if (rsp_pos_horizontal !== want.pos_horizontal) begin
               error_count++;
               $error("pos_horizontal expected %0d actual %0d",
                      want.pos_horizontal, rsp_pos_horizontal);
            end
            if (rsp_pos_vertical !== want.pos_vertical) begin
               error_count++;
               $error("pos_vertical expected %0d actual %0d",
                      want.pos_vertical, rsp_pos_vertical);
            end
         end
      end
   end

   // Watchdog: ends the run when no word or register write moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_STICKS * 2; i++) kept_axis[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zone_extremes();
      test_unused_registers();
      test_radius_sweep();
      test_output_holdoff();
      test_random_traffic();
      drain();
      if (pending_positions.size() != 0) error_count++;
      repeat (70) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
